// File: design/ttup_pkg.sv
`default_nettype none
package ttup_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int VALUE_BITS  = 32;
    localparam int BASE_BITS   = 6;
    localparam int CHAR_BITS   = 8;
    localparam int STOP_BITS   = 16;
    localparam int PROD_BITS   = VALUE_BITS + BASE_BITS + 1;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;

    localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_BITS-1:0] NO_DIGIT  = '1;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_BASE,
        PH_AUTO0,
        PH_HEX0,
        PH_HEXX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_phase                 phase;
        logic [BASE_BITS-1:0]   base;
        logic [VALUE_BITS-1:0]  acc;
        logic                   neg;
        logic                   ovf;
        logic                   dig;
        logic [OFFSET_BITS-1:0] cpos;
        logic [OFFSET_BITS-1:0] spos;
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic [CHAR_BITS-1:0] ch;
    } t_char_req;

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_x(input logic [CHAR_BITS-1:0] c);
        return (c == CH_LX) || (c == CH_UX);
    endfunction

    function automatic logic [BASE_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] d;
        d = CHAR_BITS'(NO_DIGIT);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA + 8'd10;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + 8'd10;
        end
        return d[BASE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// File: design/ttup_in_stage.sv
`default_nettype none
module ttup_in_stage (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [ttup_pkg::CHAR_BITS-1:0] i_text_char,
    output logic                               o_stall,
    input  wire logic                          i_take,
    output ttup_pkg::t_char_req                o_req
);

    logic                          r_valid;
    logic [ttup_pkg::CHAR_BITS-1:0] r_char;
    logic                          accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_text_char;
        end
    end

    assign o_req.valid = r_valid;
    assign o_req.ch    = r_char;

endmodule
`default_nettype wire

// File: design/ttup_step.sv
`default_nettype none
module ttup_step (
    input  wire ttup_pkg::t_state               i_cur,
    input  wire logic [ttup_pkg::CHAR_BITS-1:0] i_char,
    input  wire logic [ttup_pkg::BASE_BITS-1:0] i_number_base,
    output ttup_pkg::t_state                    o_next
);

    always_comb begin
        ttup_pkg::t_state                       n;
        logic                                   go;
        logic [ttup_pkg::BASE_BITS-1:0]         d;
        logic [ttup_pkg::PROD_BITS-1:0]         prod;
        n    = i_cur;
        go   = 1'b1;
        d    = ttup_pkg::digit_value(i_char);
        prod = '0;

        if (n.phase == ttup_pkg::PH_SPACE) begin
            if (ttup_pkg::is_space(i_char)) begin
                go = 1'b0;
            end else begin
                n.phase = ttup_pkg::PH_BASE;
                if (i_char == ttup_pkg::CH_MINUS) begin
                    n.neg = 1'b1;
                    go    = 1'b0;
                end else if (i_char == ttup_pkg::CH_PLUS) begin
                    go = 1'b0;
                end
            end
        end

        if (go && n.phase == ttup_pkg::PH_BASE) begin
            if (i_number_base == ttup_pkg::BASE_AUTO) begin
                if (i_char == ttup_pkg::CH_ZERO) begin
                    n.phase = ttup_pkg::PH_AUTO0;
                    go      = 1'b0;
                end else begin
                    n.base  = ttup_pkg::BASE_DEC;
                    n.phase = ttup_pkg::PH_DIGITS;
                end
            end else if (i_number_base < ttup_pkg::BASE_MIN ||
                         i_number_base > ttup_pkg::BASE_MAX) begin
                n.phase = ttup_pkg::PH_DONE;
                go      = 1'b0;
            end else begin
                n.base = i_number_base;
                if (i_number_base == ttup_pkg::BASE_OCT) begin
                    n.phase = ttup_pkg::PH_DIGITS;
                    if (i_char == ttup_pkg::CH_ZERO) begin
                        go = 1'b0;
                    end
                end else if (i_number_base == ttup_pkg::BASE_HEX) begin
                    n.phase = ttup_pkg::PH_HEX0;
                end else begin
                    n.phase = ttup_pkg::PH_DIGITS;
                end
            end
        end

        if (go && n.phase == ttup_pkg::PH_AUTO0) begin
            if (ttup_pkg::is_x(i_char)) begin
                n.base  = ttup_pkg::BASE_HEX;
                n.phase = ttup_pkg::PH_HEX0;
                go      = 1'b0;
            end else begin
                n.base  = ttup_pkg::BASE_OCT;
                n.phase = ttup_pkg::PH_DIGITS;
                if (i_char == ttup_pkg::CH_ZERO) begin
                    go = 1'b0;
                end
            end
        end

        if (go && n.phase == ttup_pkg::PH_HEX0) begin
            if (i_char == ttup_pkg::CH_ZERO) begin
                n.phase = ttup_pkg::PH_HEXX;
                go      = 1'b0;
            end else begin
                n.phase = ttup_pkg::PH_DIGITS;
            end
        end

        if (go && n.phase == ttup_pkg::PH_HEXX) begin
            n.phase = ttup_pkg::PH_DIGITS;
            if (ttup_pkg::is_x(i_char)) begin
                go = 1'b0;
            end
        end

        if (go && n.phase == ttup_pkg::PH_DIGITS) begin
            if (d >= n.base) begin
                n.spos  = n.cpos;
                n.phase = ttup_pkg::PH_DONE;
            end else begin
                prod = ttup_pkg::PROD_BITS'(n.acc) * ttup_pkg::PROD_BITS'(n.base)
                     + ttup_pkg::PROD_BITS'(d);
                if (prod[ttup_pkg::PROD_BITS-1:ttup_pkg::VALUE_BITS] != '0) begin
                    n.ovf = 1'b1;
                end else begin
                    n.acc = prod[ttup_pkg::VALUE_BITS-1:0];
                    n.dig = 1'b1;
                end
            end
        end

        // position counts every non-terminating character
        if (n.cpos != ttup_pkg::POS_MAX) begin
            n.cpos = n.cpos + 1'b1;
        end

        o_next = n;
    end

endmodule
`default_nettype wire

// File: design/ttup_parser.sv
`default_nettype none
module ttup_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ttup_pkg::t_char_req             i_req,
    input  wire logic [ttup_pkg::BASE_BITS-1:0]  i_number_base,
    output logic                                 o_take,
    input  wire logic                            i_stall,
    output logic                                 o_valid,
    output logic [ttup_pkg::VALUE_BITS-1:0]      o_parsed_value,
    output logic [ttup_pkg::STOP_BITS-1:0]       o_stop_offset,
    output logic                                 o_overflowed,
    output logic                                 o_any_converted
);

    localparam ttup_pkg::t_state STATE_CLEAR = '{
        phase: ttup_pkg::PH_SPACE,
        base:  '0,
        acc:   '0,
        neg:   1'b0,
        ovf:   1'b0,
        dig:   1'b0,
        cpos:  '0,
        spos:  '0
    };

    ttup_pkg::t_state                    r_state;
    ttup_pkg::t_state                    n_state;
    ttup_pkg::t_state                    step_next;
    logic                                is_end;
    logic                                out_free;
    logic [ttup_pkg::VALUE_BITS-1:0]     sat_value;
    logic [ttup_pkg::OFFSET_BITS-1:0]    stop_pos;
    logic                                r_valid;
    logic [ttup_pkg::VALUE_BITS-1:0]     r_value;
    logic [ttup_pkg::STOP_BITS-1:0]      r_offset;
    logic                                r_ovf;
    logic                                r_dig;

    ttup_step u_step (
        .i_cur         (r_state),
        .i_char        (i_req.ch),
        .i_number_base (i_number_base),
        .o_next        (step_next)
    );

    assign is_end   = (i_req.ch == ttup_pkg::CH_NUL);
    assign out_free = !r_valid || !i_stall;
    assign o_take   = i_req.valid && (!is_end || out_free);

    assign sat_value = r_state.ovf ? '1 : r_state.acc;
    assign stop_pos  = (r_state.phase != ttup_pkg::PH_DONE) ? r_state.cpos : r_state.spos;

    always_comb begin
        n_state = r_state;
        if (o_take) begin
            n_state = is_end ? STATE_CLEAR : step_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_take && is_end) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && is_end) begin
            r_value  <= r_state.neg ? (~sat_value + 1'b1) : sat_value;
            r_offset <= r_state.dig ? ttup_pkg::STOP_BITS'(stop_pos) : '0;
            r_ovf    <= r_state.ovf;
            r_dig    <= r_state.dig;
        end
    end

    assign o_valid         = r_valid;
    assign o_parsed_value  = r_value;
    assign o_stop_offset   = r_offset;
    assign o_overflowed    = r_ovf;
    assign o_any_converted = r_dig;

endmodule
`default_nettype wire

// File: design/text_to_unsigned_parser_core.sv
// path: terminating zero -> input stage -> result register -> o_valid
// throughput: one character per cycle (a terminating zero waits while a
// result stalls), set by the parse stage's combinational multiply-add
// reset: synchronous active low; clears the parse, both pipeline valids
// and the base register (auto-detect)
`default_nettype none
module text_to_unsigned_parser_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [ttup_pkg::BASE_BITS-1:0]  i_cfg_wr_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [ttup_pkg::CHAR_BITS-1:0]  i_text_char,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [ttup_pkg::VALUE_BITS-1:0]      o_parsed_value,
    output logic [ttup_pkg::STOP_BITS-1:0]       o_stop_offset,
    output logic                                 o_overflowed,
    output logic                                 o_any_converted
);

    logic [ttup_pkg::BASE_BITS-1:0] r_number_base;
    ttup_pkg::t_char_req            char_req;
    logic                           take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= ttup_pkg::BASE_AUTO;
        end else if (i_cfg_wr_en) begin
            r_number_base <= i_cfg_wr_data;
        end
    end

    ttup_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_text_char (i_text_char),
        .o_stall     (o_stall),
        .i_take      (take),
        .o_req       (char_req)
    );

    ttup_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (char_req),
        .i_number_base   (r_number_base),
        .o_take          (take),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_parsed_value  (o_parsed_value),
        .o_stop_offset   (o_stop_offset),
        .o_overflowed    (o_overflowed),
        .o_any_converted (o_any_converted)
    );

endmodule
`default_nettype wire

// File: design/ttup_checker.sv
`default_nettype none
module ttup_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire logic [ttup_pkg::CHAR_BITS-1:0]  i_text_char,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [ttup_pkg::VALUE_BITS-1:0] o_parsed_value,
    input wire logic [ttup_pkg::STOP_BITS-1:0]  o_stop_offset,
    input wire logic                            o_overflowed,
    input wire logic                            o_any_converted
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_parsed_value)
            && $stable(o_stop_offset) && $stable(o_overflowed)
            && $stable(o_any_converted))
        else $error("result changed while stalled");

    // no digit means no offset and no overflow
    a_no_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_any_converted |-> o_stop_offset == '0 && !o_overflowed)
        else $error("offset or overflow without converted digit");

    // a new result must follow an accepted terminating request
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_text_char == ttup_pkg::CH_NUL, 2))
        else $error("result without terminating request");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid after reset");

endmodule

bind text_to_unsigned_parser_core ttup_checker u_ttup_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_text_char     (i_text_char),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_parsed_value  (o_parsed_value),
    .o_stop_offset   (o_stop_offset),
    .o_overflowed    (o_overflowed),
    .o_any_converted (o_any_converted)
);
`default_nettype wire
